FILE: src/eptw_pkg.sv
// Shared types, codes and helper functions for the EPT page walk stepper.
package eptw_pkg;

    // Item codes.
    localparam logic       REQ_START = 1'b0;
    localparam logic       REQ_ENTRY = 1'b1;

    // Entry kinds as reported on the result channel.
    localparam logic [1:0] KIND_NOT_PRESENT = 2'd0;
    localparam logic [1:0] KIND_MMIO        = 2'd1;
    localparam logic [1:0] KIND_POINTER     = 2'd2;
    localparam logic [1:0] KIND_LEAF        = 2'd3;

    // Walk levels.
    localparam logic [2:0] LVL_NONE = 3'd0;
    localparam logic [2:0] LVL_PT   = 3'd1;
    localparam logic [2:0] LVL_PD   = 3'd2;
    localparam logic [2:0] LVL_PDPT = 3'd3;
    localparam logic [2:0] LVL_PML4 = 3'd4;

    // A classified request as it waits between the front and the back.
    typedef struct packed {
        logic        req_type;
        logic [47:0] guest_address;
        logic        root_bad;
        logic [39:0] root_frame;
        logic        is_mmio;
        logic        is_present;
        logic        is_large;
        logic [4:0]  flags;
        logic [39:0] entry_frame;
    } t_item;

    // One result as it waits for the receiver.
    typedef struct packed {
        logic [51:0] read_address;
        logic        fetch_next;
        logic [2:0]  entry_level;
        logic [8:0]  slot_index;
        logic [51:0] table_address;
        logic [1:0]  entry_kind;
        logic [4:0]  entry_flags;
        logic        walk_done;
        logic        mapped;
        logic        mmio_hit;
        logic [2:0]  final_level;
        logic [39:0] leaf_frame;
    } t_result;

    // Nine guest address bits that select the entry at a level.
    function automatic logic [8:0] slot_of(input logic [47:0] gpa, input logic [2:0] lvl);
        logic [8:0] slot;
        unique case (lvl)
            LVL_PML4: slot = gpa[47:39];
            LVL_PDPT: slot = gpa[38:30];
            LVL_PD:   slot = gpa[29:21];
            default:  slot = gpa[20:12];
        endcase
        return slot;
    endfunction

    // Page offset, in 4 KiB frames, of a large page at a level.
    function automatic logic [26:0] leaf_offset(input logic [47:0] gpa,
                                                input logic [2:0] lvl);
        logic [26:0] off;
        unique case (lvl)
            LVL_PD:   off = {18'd0, gpa[20:12]};
            LVL_PDPT: off = {9'd0, gpa[29:12]};
            LVL_PML4: off = gpa[38:12];
            default:  off = '0;
        endcase
        return off;
    endfunction

endpackage

FILE: src/ept_page_walk_step_top.sv
// Top level of the four-level EPT page walk stepper.
//
// Requests enter through a queue-style port: a request is taken at a rising
// edge with push high and full low. A start request carries the guest
// physical address and root table address; an entry request carries the
// 64-bit entry word read at the last read address given out.
// Every request yields exactly one result, offered while empty is low and
// taken at a rising edge with pop high. A result either asks for the next
// entry (fetch_next), or reports the fetched entry and, when the walk ends,
// its outcome (mapped, MMIO marker or missing) and the host frame.
// An accepted request is registered in the classifying request queue; the
// walk stage then takes it, when the result queue is not full or is being
// popped, and writes its result into the result queue, from which the
// receiver pops it. Throughput is one request per cycle unless the result
// queue is full and not popped; the walk stage updates its state as it
// takes each request, so entries of one walk may follow each other back to
// back. The real pace is set by the memory that returns the entry words.
// Reset clears both queues and the walk state (no walk active). When the
// receiver stops popping, the two-entry result queue and the two-entry
// request queue fill, and then full rises.
module ept_page_walk_step_top
    import eptw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [47:0] i_guest_address,
    input  logic [63:0] i_root_address,
    input  logic [63:0] i_entry_word,
    output logic        empty,
    input  logic        pop,
    output logic [51:0] o_read_address,
    output logic        o_fetch_next,
    output logic [2:0]  o_entry_level,
    output logic [8:0]  o_slot_index,
    output logic [51:0] o_table_address,
    output logic [1:0]  o_entry_kind,
    output logic [4:0]  o_entry_flags,
    output logic        o_walk_done,
    output logic        o_mapped,
    output logic        o_mmio_hit,
    output logic [2:0]  o_final_level,
    output logic [39:0] o_leaf_frame
);

    logic    w_valid;
    logic    w_take;
    t_item   w_item;
    t_result w_res;

    // Front end: classify and queue requests.
    eptw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_req_type      (i_req_type),
        .i_guest_address (i_guest_address),
        .i_root_address  (i_root_address),
        .i_entry_word    (i_entry_word),
        .o_valid         (w_valid),
        .o_item          (w_item),
        .i_take          (w_take)
    );

    // Back end: step the walk and queue results.
    eptw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid),
        .i_item   (w_item),
        .o_take   (w_take),
        .o_empty  (empty),
        .o_result (w_res),
        .i_pop    (pop)
    );

    assign o_read_address  = w_res.read_address;
    assign o_fetch_next    = w_res.fetch_next;
    assign o_entry_level   = w_res.entry_level;
    assign o_slot_index    = w_res.slot_index;
    assign o_table_address = w_res.table_address;
    assign o_entry_kind    = w_res.entry_kind;
    assign o_entry_flags   = w_res.entry_flags;
    assign o_walk_done     = w_res.walk_done;
    assign o_mapped        = w_res.mapped;
    assign o_mmio_hit      = w_res.mmio_hit;
    assign o_final_level   = w_res.final_level;
    assign o_leaf_frame    = w_res.leaf_frame;

    // Reset leaves both queues empty.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // A result never both asks for a fetch and ends the walk.
    a_fetch_or_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_fetch_next) |-> !o_walk_done)
        else $error("result both fetches and finishes");

    // A mapped result always reports a leaf at a real level.
    a_mapped_leaf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_mapped) |-> (o_entry_kind == KIND_LEAF && o_final_level != LVL_NONE
                                  && o_walk_done))
        else $error("mapped result without a leaf");

    // Final fields stay clear until the walk finishes.
    a_final_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_walk_done) |-> (!o_mapped && !o_mmio_hit && o_leaf_frame == 40'd0))
        else $error("final fields set on an unfinished walk");

endmodule

FILE: src/eptw_front.sv
// Front end: classifies incoming requests and holds them in a two-entry queue.
module eptw_front
    import eptw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_req_type,
    input  logic [47:0] i_guest_address,
    input  logic [63:0] i_root_address,
    input  logic [63:0] i_entry_word,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_take
);

    t_item       r_mem [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    t_item       n_item;
    logic        w_push_ok, w_take_ok;
    logic [63:0] w_word;

    assign w_word = i_entry_word;

    // Classify the request; none of this depends on walk state.
    always_comb begin
        n_item.req_type      = i_req_type;
        n_item.guest_address = i_guest_address;
        n_item.root_bad      = (i_root_address == 64'd0) || (&i_root_address);
        n_item.root_frame    = i_root_address[51:12];
        n_item.is_mmio       = (w_word != 64'd0) &&
                               ({w_word[63], w_word[2:0]} == 4'b0110);
        n_item.is_present    = !n_item.is_mmio && (|w_word[2:0]);
        n_item.is_large      = w_word[7];
        n_item.flags         = {w_word[9], w_word[8], w_word[2:0]};
        n_item.entry_frame   = w_word[51:12];
    end

    assign o_full    = (r_cnt == 2'd2);
    assign o_valid   = (r_cnt != 2'd0);
    assign o_item    = r_mem[r_rd_ptr];
    assign w_push_ok = i_push && !o_full;
    assign w_take_ok = i_take && o_valid;

    // Occupancy of the request queue.
    always_comb begin
        n_cnt = r_cnt;
        if (w_push_ok && !w_take_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push_ok && w_take_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Queue pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push_ok) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_take_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr_ptr] <= n_item;
        end
    end

endmodule

FILE: src/eptw_back.sv
// Back end: holds the walk state, builds one result per request and queues it.
module eptw_back
    import eptw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_take,
    output logic    o_empty,
    output t_result o_result,
    input  logic    i_pop
);

    // Walk state.
    logic        r_active, n_active;
    logic [2:0]  r_level, n_level;
    logic [47:0] r_gpa, n_gpa;
    logic [39:0] r_base, n_base;

    // Result queue.
    t_result     r_mem [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_cnt, n_cnt;
    logic        w_pop_ok;
    t_result     n_res;
    logic [2:0]  w_next_lvl;

    assign o_empty  = (r_cnt == 2'd0);
    assign o_result = r_mem[r_rd_ptr];
    assign w_pop_ok = i_pop && !o_empty;
    assign o_take   = i_valid && ((r_cnt != 2'd2) || w_pop_ok);
    assign w_next_lvl = r_level - 3'd1;

    // Step the walk for the request at the head of the front queue.
    always_comb begin
        n_res    = '0;
        n_active = r_active;
        n_level  = r_level;
        n_gpa    = r_gpa;
        n_base   = r_base;
        if (i_item.req_type == REQ_START) begin
            n_gpa = i_item.guest_address;
            if (i_item.root_bad) begin
                n_active        = 1'b0;
                n_level         = LVL_NONE;
                n_base          = '0;
                n_res.walk_done = 1'b1;
            end else begin
                n_active           = 1'b1;
                n_level            = LVL_PML4;
                n_base             = i_item.root_frame;
                n_res.read_address = {i_item.root_frame,
                                      slot_of(i_item.guest_address, LVL_PML4), 3'd0};
                n_res.fetch_next   = 1'b1;
            end
        end else if (r_active) begin
            n_res.entry_level   = r_level;
            n_res.slot_index    = slot_of(r_gpa, r_level);
            n_res.table_address = {r_base, 12'd0};
            n_res.entry_flags   = i_item.flags;
            if (i_item.is_mmio) begin
                n_res.entry_kind = KIND_MMIO;
                n_res.walk_done  = 1'b1;
                n_res.mmio_hit   = 1'b1;
                n_active         = 1'b0;
            end else if (!i_item.is_present) begin
                n_res.entry_kind = KIND_NOT_PRESENT;
                n_res.walk_done  = 1'b1;
                n_active         = 1'b0;
            end else if ((r_level <= LVL_PT) || i_item.is_large) begin
                n_res.entry_kind  = KIND_LEAF;
                n_res.walk_done   = 1'b1;
                n_res.mapped      = 1'b1;
                n_res.final_level = r_level;
                n_res.leaf_frame  = i_item.entry_frame + 40'(leaf_offset(r_gpa, r_level));
                n_active          = 1'b0;
            end else begin
                n_res.entry_kind   = KIND_POINTER;
                n_level            = w_next_lvl;
                n_base             = i_item.entry_frame;
                n_res.read_address = {i_item.entry_frame, slot_of(r_gpa, w_next_lvl), 3'd0};
                n_res.fetch_next   = 1'b1;
            end
        end
    end

    // Occupancy of the result queue.
    always_comb begin
        n_cnt = r_cnt;
        if (o_take && !w_pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!o_take && w_pop_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Walk state and queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_level  <= LVL_NONE;
            r_gpa    <= '0;
            r_base   <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (o_take) begin
                r_active <= n_active;
                r_level  <= n_level;
                r_gpa    <= n_gpa;
                r_base   <= n_base;
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_mem[r_wr_ptr] <= n_res;
        end
    end

endmodule
